/* sv/fp32a_pkg.sv */
// Shared constants for the binary32 adder.
package fp32a_pkg;
   localparam logic [22:0] MANT_MASK   = 23'h7FFFFF;
   localparam logic [7:0]  EXP_MAX     = 8'hFF;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
   localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
   localparam logic [30:0] MAX_FINITE  = 31'h7F7F_FFFF;
   localparam int          TOP_POS     = 26;
endpackage

/* sv/fp32_adder_core.sv */
// Pipelined binary32 adder, round toward zero, flush-to-zero.
//  channel | ports                           | direction
//  req     | req_valid req_ready req_operand_a/b | in
//  rsp     | rsp_valid rsp_ready rsp_sum_bits    | out
// Four register stages: unpack/swap, align/add, leading-one count, normalize/pack.
// One item per cycle while rsp_ready stays high; the last stage drives the rsp ports.
// Reset clears the valid bits only.
// A stall freezes only the stages that hold an item with no empty stage below them; bubbles are squeezed out.
module fp32_adder_core import fp32a_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_sum_bits
);
   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   assign en4 = !v4_ff || rsp_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_ready = en1;

   // stage 1: classify, order
   logic        s1_spec_ff, s1_sr_ff, s1_sub_ff;
   logic [31:0] s1_spec_val_ff;
   logic [7:0]  s1_ea_ff, s1_d_ff;
   logic [23:0] s1_ma_ff, s1_mb_ff;
   logic        s1_spec_in, s1_sr_in, s1_sub_in;
   logic [31:0] s1_spec_val_in;
   logic [7:0]  s1_ea_in, s1_d_in;
   logic [23:0] s1_ma_in, s1_mb_in;

   always_comb begin
      logic [7:0]  ea, eb;
      logic [23:0] ma, mb;
      logic        an, bn, ai, bi, az, bz, sw;
      ea = req_operand_a[30:23];
      eb = req_operand_b[30:23];
      ma = {1'b1, req_operand_a[22:0]};
      mb = {1'b1, req_operand_b[22:0]};
      an = (ea == EXP_MAX) && (req_operand_a[22:0] != 23'd0);
      bn = (eb == EXP_MAX) && (req_operand_b[22:0] != 23'd0);
      ai = (ea == EXP_MAX) && !an;
      bi = (eb == EXP_MAX) && !bn;
      az = (ea == 8'd0);
      bz = (eb == 8'd0);
      s1_spec_in = 1'b1;
      s1_spec_val_in = 32'd0;
      if (an) s1_spec_val_in = req_operand_a | QUIET_BIT;
      else if (bn) s1_spec_val_in = req_operand_b | QUIET_BIT;
      else if (ai && bi)
         s1_spec_val_in = (req_operand_a[31] != req_operand_b[31]) ? DEFAULT_NAN
                                                                    : req_operand_a;
      else if (ai) s1_spec_val_in = req_operand_a;
      else if (bi) s1_spec_val_in = req_operand_b;
      else if (az && bz)
         s1_spec_val_in = {req_operand_a[31] & req_operand_b[31], 31'd0};
      else if (az) s1_spec_val_in = req_operand_b;
      else if (bz) s1_spec_val_in = req_operand_a;
      else s1_spec_in = 1'b0;
      sw = (eb > ea) || ((eb == ea) && (mb > ma));
      s1_sr_in  = sw ? req_operand_b[31] : req_operand_a[31];
      s1_sub_in = req_operand_a[31] != req_operand_b[31];
      s1_ea_in  = sw ? eb : ea;
      s1_d_in   = sw ? (eb - ea) : (ea - eb);
      s1_ma_in  = sw ? mb : ma;
      s1_mb_in  = sw ? ma : mb;
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en1) v1_ff <= req_valid;
      if (en1) begin
         s1_spec_ff <= s1_spec_in; s1_spec_val_ff <= s1_spec_val_in;
         s1_sr_ff <= s1_sr_in; s1_sub_ff <= s1_sub_in;
         s1_ea_ff <= s1_ea_in; s1_d_ff <= s1_d_in;
         s1_ma_ff <= s1_ma_in; s1_mb_ff <= s1_mb_in;
      end
   end

   // stage 2: align and add
   logic [31:0] s2_val_ff, s2_val_in;
   logic        s2_spec_ff, s2_sr_ff;
   logic [31:0] s2_spec_val_ff;
   logic [7:0]  s2_ea_ff;

   always_comb begin
      logic [4:0]  d;
      logic [31:0] big, sm, shd;
      logic        lost;
      d    = (s1_d_ff > 8'd31) ? 5'd31 : s1_d_ff[4:0];
      big  = {5'd0, s1_ma_ff, 3'd0};
      sm   = {5'd0, s1_mb_ff, 3'd0};
      shd  = sm >> d;
      lost = (sm & ((32'd1 << d) - 32'd1)) != 32'd0;
      s2_val_in = s1_sub_ff ? (big - shd - {31'd0, lost}) : (big + shd);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en2) v2_ff <= v1_ff;
      if (en2) begin
         s2_val_ff <= s2_val_in; s2_spec_ff <= s1_spec_ff;
         s2_spec_val_ff <= s1_spec_val_ff; s2_sr_ff <= s1_sr_ff; s2_ea_ff <= s1_ea_ff;
      end
   end

   // stage 3: leading-one position (value at most 28 bits)
   logic [4:0]  s3_pos_ff, s3_pos_in;
   logic [31:0] s3_val_ff;
   logic        s3_spec_ff, s3_sr_ff;
   logic [31:0] s3_spec_val_ff;
   logic [7:0]  s3_ea_ff;

   always_comb begin
      s3_pos_in = 5'd0;
      for (int i = 0; i < 32; i++)
         if (s2_val_ff[i]) s3_pos_in = 5'(i);
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en3) v3_ff <= v2_ff;
      if (en3) begin
         s3_pos_ff <= s3_pos_in; s3_val_ff <= s2_val_ff; s3_spec_ff <= s2_spec_ff;
         s3_spec_val_ff <= s2_spec_val_ff; s3_sr_ff <= s2_sr_ff; s3_ea_ff <= s2_ea_ff;
      end
   end

   // stage 4: normalize and pack
   logic [31:0] s4_res_ff, s4_res_in;
   always_comb begin
      logic [31:0] v;
      logic signed [9:0] er;
      v  = s3_val_ff;
      er = signed'({2'd0, s3_ea_ff});
      if (32'(s3_pos_ff) > TOP_POS) begin
         v  = v >> (s3_pos_ff - 5'(TOP_POS));
         er = er + signed'({5'd0, s3_pos_ff - 5'(TOP_POS)});
      end else begin
         v  = v << (5'(TOP_POS) - s3_pos_ff);
         er = er - signed'({5'd0, 5'(TOP_POS) - s3_pos_ff});
      end
      if (s3_spec_ff) s4_res_in = s3_spec_val_ff;
      else if (s3_val_ff == 32'd0) s4_res_in = 32'd0;
      else if (er >= 10'sd255) s4_res_in = {s3_sr_ff, MAX_FINITE};
      else if (er <= 10'sd0) s4_res_in = {s3_sr_ff, 31'd0};
      else s4_res_in = {s3_sr_ff, er[7:0], v[25:3] & MANT_MASK};
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en4) v4_ff <= v3_ff;
      if (en4) s4_res_ff <= s4_res_in;
   end

   assign rsp_valid    = v4_ff;
   assign rsp_sum_bits = s4_res_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum_bits))
      else $error("result changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("stalled with empty output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !en4 |=> v3_ff)
      else $error("item lost in stage three");
endmodule

/* verif/tb_fp32_adder_core.sv */
// Self-checking testbench for the binary32 round-toward-zero adder.
`timescale 1ns / 100ps
module tb_fp32_adder_core;
   import fp32a_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
   } operand_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_sum_bits;

   operand_pair_type pending_pairs[$];
   logic [31:0]   expected_sums[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  quiet_mode = 1'b0;
   bit  hold_sender = 1'b0;
   bit  stim_done = 1'b0;
   bit  req_fire = 1'b0;

   fp32_adder_core DUT (.*);

   always #2 clock = ~clock;

   function automatic logic [31:0] rtz_sum(input logic [31:0] a, input logic [31:0] b);
      logic        sa, sb, sr, a_nan, b_nan, a_inf, b_inf, lost;
      logic [7:0]  ea, eb, et;
      logic [23:0] ma, mb, mt;
      logic [31:0] big, val;
      logic [63:0] sml;
      int          d, pos, er;
      ea = a[30:23];
      eb = b[30:23];
      a_nan = (ea == EXP_MAX) && (a[22:0] != 0);
      b_nan = (eb == EXP_MAX) && (b[22:0] != 0);
      a_inf = (ea == EXP_MAX) && !a_nan;
      b_inf = (eb == EXP_MAX) && !b_nan;
      if (a_nan) return a | QUIET_BIT;
      if (b_nan) return b | QUIET_BIT;
      if (a_inf && b_inf) return (a[31] ^ b[31]) ? DEFAULT_NAN : a;
      if (a_inf) return a;
      if (b_inf) return b;
      if (ea == 0 && eb == 0) return a & b & SIGN_MASK;
      if (ea == 0) return b;
      if (eb == 0) return a;
      sa = a[31];
      sb = b[31];
      ma = {1'b1, a[22:0]};
      mb = {1'b1, b[22:0]};
      if (eb > ea || (eb == ea && mb > ma)) begin
         sr = sa; sa = sb; sb = sr;
         et = ea; ea = eb; eb = et;
         mt = ma; ma = mb; mb = mt;
      end
      sr = sa;
      d = ea - eb;
      if (d > 31) d = 31;
      big = {5'b0, ma, 3'b0};
      sml = {37'b0, mb, 3'b0};
      lost = (sml & ((64'd1 << d) - 64'd1)) != 0;
      sml = sml >> d;
      if (sa == sb) val = big + sml[31:0];
      else val = big - sml[31:0] - {31'b0, lost};
      if (val == 0) return '0;
      pos = 31;
      while (pos > 0 && !val[pos]) pos--;
      er = ea;
      if (pos > TOP_POS) begin
         val = val >> (pos - TOP_POS);
         er += pos - TOP_POS;
      end else if (pos < TOP_POS) begin
         val = val << (TOP_POS - pos);
         er -= TOP_POS - pos;
      end
      if (er >= int'(EXP_MAX)) return {sr, MAX_FINITE};
      if (er <= 0) return {sr, 31'b0};
      return {sr, er[7:0], val[25:3]};
   endfunction

   function automatic logic [31:0] rand_float();
      logic [31:0] x;
      x = $urandom;
      case ($urandom_range(0, 9))
         0: x[30:23] = 8'hFF;
         1: x[30:23] = 8'h00;
         2: x[30:23] = $urandom_range(0, 1) ? 8'hFE : 8'h01;
         3: x[22:0] = $urandom_range(0, 1) ? 23'h0 : 23'h7FFFFF;
         default: x[30:23] = 8'($urandom_range(100, 154));
      endcase
      return x;
   endfunction

   task automatic add_pair(input logic [31:0] a, input logic [31:0] b);
      pending_pairs.push_back('{a: a, b: b});
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= quiet_mode ? 1'b1 : ($urandom_range(0, 99) >= 15);
         if (!req_valid || req_fire) begin
            if (!hold_sender && pending_pairs.size() > 0 &&
                (quiet_mode || $urandom_range(0, 99) >= 15)) begin
               req_valid     <= 1'b1;
               req_operand_a <= pending_pairs[0].a;
               req_operand_b <= pending_pairs[0].b;
               void'(pending_pairs.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready)
            expected_sums.push_back(rtz_sum(req_operand_a, req_operand_b));
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, rsp_sum_bits);
               error_count++;
            end else begin
               if (rsp_sum_bits !== expected_sums[0]) begin
                  $display("%0t: sum_bits mismatch, expected %h actual %h",
                           $time, expected_sums[0], rsp_sum_bits);
                  error_count++;
               end
               void'(expected_sums.pop_front());
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (pending_pairs.size() == 0 && expected_sums.size() == 0 && !req_valid))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT && !stim_done) begin
            $display("FAIL fp32_adder_core");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] a, b;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      add_pair(32'h3F80_0000, 32'h3F80_0000);
      add_pair(32'h3F80_0000, 32'hBF80_0000);   // exact cancellation
      add_pair(32'h8000_0000, 32'h8000_0000);
      add_pair(32'h0000_0000, 32'h8000_0000);
      add_pair(32'h8000_0001, 32'h4040_0000);   // subnormal operand
      add_pair(32'h0000_0000, 32'h807F_FFFF);
      add_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow
      add_pair(32'hFF7F_FFFF, 32'hFF00_0000);
      add_pair(32'h0080_0001, 32'h8080_0000);   // subnormal result
      add_pair(32'h7F80_0000, 32'hFF80_0000);
      add_pair(32'hFF80_0000, 32'hFF80_0000);
      add_pair(32'h7F80_0000, 32'h3F80_0000);
      add_pair(32'h3F80_0000, 32'hFF80_0000);
      add_pair(32'h7F80_0001, 32'hFFC0_0000);   // both NaN
      add_pair(32'h3F80_0000, 32'hFF80_1234);
      add_pair(32'h4B80_0000, 32'hB380_0001);   // far alignment, sticky
      add_pair(32'h3F80_0000, 32'hB3FF_FFFF);
      add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_pair(32'h3F7F_FFFF, 32'hBF80_0000);
      add_pair(32'h4000_0000, 32'hBFFF_FFFF);

      while (pending_pairs.size() > 0 || req_valid || expected_sums.size() > 0)
         @(posedge clock);
      hold_sender = 1'b1;
      repeat (3) @(posedge clock);
      hold_sender = 1'b0;

      for (int i = 0; i < 1630; i++) begin
         a = rand_float();
         case ($urandom_range(0, 3))
            0: b = {~a[31], a[30:23], a[22:0] ^ 23'($urandom_range(0, 7))};
            1: b = {$urandom_range(0, 1) ? 1'b1 : 1'b0, a[30:23] - 8'($urandom_range(0, 30)),
                    23'($urandom)};
            default: b = rand_float();
         endcase
         add_pair(a, b);
         if (i == 400) quiet_mode = 1'b1;
         if (i == 700) quiet_mode = 1'b0;
         while (pending_pairs.size() > 64) @(posedge clock);
      end

      while (pending_pairs.size() > 0 || req_valid || expected_sums.size() > 0)
         @(posedge clock);
      stim_done = 1'b1;
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_sums.size() == 0)
         $display("PASS fp32_adder_core");
      else
         $display("FAIL fp32_adder_core");
      $finish;
   end
endmodule
